// ===== hdl/tlbpt_pkg.sv =====
// Package with the shared constants and item types of the TLB and page table translator.
`timescale 1ns / 1ps
`default_nettype none
package tlbpt_pkg;

  localparam int PAGE_OFFSET_BITS = 12;
  localparam int NUM_VIRTUAL_PAGES = 1024;
  localparam int TLB_ENTRIES = 16;
  localparam int NUM_FRAMES = 128;

  localparam int VA_WIDTH = 22;
  localparam int PA_WIDTH = 19;

  typedef struct packed {
    logic                action;
    logic [VA_WIDTH-1:0] virt_addr;
  } req_t;

  typedef struct packed {
    logic [PA_WIDTH-1:0] phys_addr;
    logic                tlb_hit;
    logic                page_fault;
    logic                frames_exhausted;
  } rsp_t;

endpackage
`default_nettype wire

// ===== hdl/tlbpt_tlb.sv =====
// FIFO-replaced TLB storage with a registered read port and an insert port.
`timescale 1ns / 1ps
`default_nettype none
module tlbpt_tlb #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES,
  parameter int PAGE_W = $clog2(tlbpt_pkg::NUM_VIRTUAL_PAGES),
  parameter int FRAME_W = $clog2(tlbpt_pkg::NUM_FRAMES),
  localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1,
  localparam int CNT_W = $clog2(TLB_ENTRIES + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [IDX_W-1:0]   rd_idx,
  output logic      [PAGE_W-1:0]  rd_page,
  output logic      [FRAME_W-1:0] rd_frame,
  input  wire logic               insert,
  input  wire logic [PAGE_W-1:0]  ins_page,
  input  wire logic [FRAME_W-1:0] ins_frame,
  output logic      [CNT_W-1:0]   fill_count
);

  logic [PAGE_W-1:0]  page_mem  [TLB_ENTRIES];
  logic [FRAME_W-1:0] frame_mem [TLB_ENTRIES];
  logic [IDX_W-1:0]   oldest;
  logic               full;
  logic [IDX_W-1:0]   slot;

  assign full = (fill_count == CNT_W'(TLB_ENTRIES));
  assign slot = full ? oldest : fill_count[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      oldest <= '0;
    end else if (insert) begin
      if (full) begin
        oldest <= (oldest == IDX_W'(TLB_ENTRIES - 1)) ? '0 : oldest + 1'b1;
      end else begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert) begin
      page_mem[slot] <= ins_page;
      frame_mem[slot] <= ins_frame;
    end
    rd_page <= page_mem[rd_idx];
    rd_frame <= frame_mem[rd_idx];
  end

endmodule
`default_nettype wire

// ===== hdl/tlb_page_table_translator.sv =====
// Top level of the TLB and single-level page table address translator.
//
// Requests arrive on req_valid/req_ready/req, one access item each; results
// leave on rsp_valid/rsp_ready/rsp, one result item per access, in order.
// After reset the page table memory is swept clear, one entry per cycle,
// over all NUM_VIRTUAL_PAGES entries; req_ready stays low during the sweep.
// An item is taken in the idle state only. When the page count is not a
// power of two, its page number is reduced modulo NUM_VIRTUAL_PAGES by a
// reciprocal multiply in S_MOD; otherwise the S_MOD state is skipped.
// The TLB is then scanned by one comparator, one entry at a time through
// S_TLB_ADDR and S_TLB_CMP, up to the hit. A miss ends the scan in
// S_TLB_ADDR, then reads the page table in S_PT_ADDR and writes it back in
// S_PT_CHK; a write that hits also passes S_PT_ADDR and S_PT_CHK.
// The result turns valid at the edge where the block becomes ready again.
// The output register holds a result until rsp_ready takes it; a new item
// may be accepted meanwhile, and its result waits in the final state
// until the output register is free.
`timescale 1ns / 1ps
`default_nettype none
module tlb_page_table_translator #(
  parameter int PAGE_OFFSET_BITS = tlbpt_pkg::PAGE_OFFSET_BITS,
  parameter int NUM_VIRTUAL_PAGES = tlbpt_pkg::NUM_VIRTUAL_PAGES,
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES,
  parameter int NUM_FRAMES = tlbpt_pkg::NUM_FRAMES
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire tlbpt_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output tlbpt_pkg::rsp_t      rsp
);

  localparam int VaW = tlbpt_pkg::VA_WIDTH;
  localparam int PaW = tlbpt_pkg::PA_WIDTH;
  localparam int VPN_W = VaW - PAGE_OFFSET_BITS;
  localparam int PW = $clog2(NUM_VIRTUAL_PAGES);
  localparam int KW = VPN_W + PW;
  localparam int RW = VPN_W + 2;
  localparam int QW = VPN_W + RW;
  localparam longint unsigned RECIP =
    ((64'd1 << KW) + 64'(NUM_VIRTUAL_PAGES) - 64'd1) / 64'(NUM_VIRTUAL_PAGES);
  localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
  localparam int FB = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FCW = $clog2(NUM_FRAMES + 1);
  localparam int TI = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int TCW = $clog2(TLB_ENTRIES + 1);
  localparam int WW = FB + 3;
  localparam bit IS_POW2 = ((NUM_VIRTUAL_PAGES & (NUM_VIRTUAL_PAGES - 1)) == 0);

  typedef enum logic [7:0] {
    S_CLEAR    = 8'b0000_0001,
    S_IDLE     = 8'b0000_0010,
    S_MOD      = 8'b0000_0100,
    S_TLB_ADDR = 8'b0000_1000,
    S_TLB_CMP  = 8'b0001_0000,
    S_PT_ADDR  = 8'b0010_0000,
    S_PT_CHK   = 8'b0100_0000,
    S_DONE     = 8'b1000_0000
  } state_t;

  state_t                      state;
  logic                        act_q;
  logic [VPN_W-1:0]            vpn_q;
  logic [PAGE_OFFSET_BITS-1:0] off_q;
  logic [PW-1:0]               page_q;
  logic [VPN_W-1:0]            quot_q;
  logic                        step_cnt;
  logic [TCW-1:0]              scan_cnt;
  logic                        hit_q;
  logic                        fault_q;
  logic                        exh_q;
  logic [FB-1:0]               frame_q;
  logic [FCW-1:0]              frame_count;
  logic [PW-1:0]               clr_idx;

  logic [QW-1:0]               quot_prod;
  logic [KW-1:0]               quot_back;
  logic [VPN_W-1:0]            req_vpn;

  logic [WW-1:0]               pt_mem [NUM_VIRTUAL_PAGES];
  logic [WW-1:0]               pt_rd;
  logic                        pt_we;
  logic [PW-1:0]               pt_waddr;
  logic [WW-1:0]               pt_wdata;

  logic                        old_present;
  logic                        frames_left;
  logic [FB-1:0]               alloc_frame;
  logic [FB-1:0]               new_frame;
  logic [WW-1:0]               new_word;

  logic [PW-1:0]               tlb_rd_page;
  logic [FB-1:0]               tlb_rd_frame;
  logic                        tlb_insert;
  logic [TCW-1:0]              tlb_fill;

  logic [FB+PAGE_OFFSET_BITS-1:0] pa_wide;

  assign req_ready = (state == S_IDLE);
  assign req_vpn = req.virt_addr[VaW-1:PAGE_OFFSET_BITS];

  assign quot_prod = QW'(vpn_q) * QW'(RECIP_C);
  assign quot_back = KW'(quot_q) * KW'(NUM_VIRTUAL_PAGES);

  assign old_present = pt_rd[FB+2];
  assign frames_left = (frame_count < FCW'(NUM_FRAMES));
  assign alloc_frame = frames_left ? FB'(frame_count) : '0;
  assign new_frame = old_present ? pt_rd[FB-1:0] : alloc_frame;
  assign new_word = {1'b1, pt_rd[FB+1] | act_q, old_present ? pt_rd[FB] : 1'b1, new_frame};

  assign tlb_insert = (state == S_PT_CHK) && !hit_q;

  always_comb begin
    pt_we = 1'b0;
    pt_waddr = page_q;
    pt_wdata = new_word;
    if (state == S_CLEAR) begin
      pt_we = 1'b1;
      pt_waddr = clr_idx;
      pt_wdata = '0;
    end else if (state == S_PT_CHK) begin
      pt_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rd <= pt_mem[page_q];
  end

  tlbpt_tlb #(
    .TLB_ENTRIES(TLB_ENTRIES),
    .PAGE_W(PW),
    .FRAME_W(FB)
  ) u_tlb (
    .clk(clk),
    .rst(rst),
    .rd_idx(scan_cnt[TI-1:0]),
    .rd_page(tlb_rd_page),
    .rd_frame(tlb_rd_frame),
    .insert(tlb_insert),
    .ins_page(page_q),
    .ins_frame(new_frame),
    .fill_count(tlb_fill)
  );

  assign pa_wide = {frame_q, off_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_idx <= '0;
      frame_count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == PW'(NUM_VIRTUAL_PAGES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            act_q <= req.action;
            vpn_q <= req_vpn;
            off_q <= req.virt_addr[PAGE_OFFSET_BITS-1:0];
            page_q <= PW'(req_vpn);
            step_cnt <= 1'b0;
            scan_cnt <= '0;
            hit_q <= 1'b0;
            fault_q <= 1'b0;
            exh_q <= 1'b0;
            state <= IS_POW2 ? S_TLB_ADDR : S_MOD;
          end
        end
        S_MOD: begin
          if (!step_cnt) begin
            quot_q <= VPN_W'(quot_prod >> KW);
            step_cnt <= 1'b1;
          end else begin
            page_q <= PW'(vpn_q - quot_back[VPN_W-1:0]);
            state <= S_TLB_ADDR;
          end
        end
        S_TLB_ADDR: begin
          state <= (scan_cnt == tlb_fill) ? S_PT_ADDR : S_TLB_CMP;
        end
        S_TLB_CMP: begin
          if (tlb_rd_page == page_q) begin
            hit_q <= 1'b1;
            frame_q <= tlb_rd_frame;
            state <= act_q ? S_PT_ADDR : S_DONE;
          end else begin
            scan_cnt <= scan_cnt + 1'b1;
            state <= S_TLB_ADDR;
          end
        end
        S_PT_ADDR: begin
          state <= S_PT_CHK;
        end
        S_PT_CHK: begin
          if (!hit_q) begin
            frame_q <= new_frame;
            if (!old_present) begin
              fault_q <= 1'b1;
              exh_q <= !frames_left;
              if (frames_left) begin
                frame_count <= frame_count + 1'b1;
              end
            end
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp.phys_addr <= PaW'(pa_wide);
            rsp.tlb_hit <= hit_q;
            rsp.page_fault <= fault_q;
            rsp.frames_exhausted <= exh_q;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== test/tlb_page_table_translator_tb.sv =====
// Self-checking testbench for the TLB and page table translator with a local address predictor.
`timescale 1ns / 1ps
module tlb_page_table_translator_tb;

  localparam logic ACT_READ = 1'b0;
  localparam logic ACT_WRITE = 1'b1;
  localparam int PAGE_BITS = $clog2(tlbpt_pkg::NUM_VIRTUAL_PAGES);
  localparam int FRAME_BITS = $clog2(tlbpt_pkg::NUM_FRAMES);
  localparam int RANDOM_ACCESSES = 1550;
  localparam int QUIET_TAIL = 200;
  localparam int SETTLE_CYCLES = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    tlbpt_pkg::req_t access;
    logic known;
    tlbpt_pkg::rsp_t want;
  } dir_row_t;

  localparam tlbpt_pkg::rsp_t NO_RSP = '0;
  localparam int DIR_ROWS = 24;
  localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
    '{'{ACT_READ, 22'h000000}, 1'b1, '{19'h00000, 1'b0, 1'b1, 1'b0}},
    '{'{ACT_WRITE, 22'h000FFF}, 1'b1, '{19'h00FFF, 1'b1, 1'b0, 1'b0}},
    '{'{ACT_WRITE, 22'h3FFFFF}, 1'b1, '{19'h01FFF, 1'b0, 1'b1, 1'b0}},
    '{'{ACT_READ, 22'h3FF000}, 1'b1, '{19'h01000, 1'b1, 1'b0, 1'b0}},
    '{'{ACT_READ, 22'h002A5A}, 1'b0, NO_RSP},
    '{'{ACT_WRITE, 22'h0035A5}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h004001}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h005FFE}, 1'b0, NO_RSP},
    '{'{ACT_WRITE, 22'h006123}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h007456}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h008789}, 1'b0, NO_RSP},
    '{'{ACT_WRITE, 22'h009ABC}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h00ADEF}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h00B800}, 1'b0, NO_RSP},
    '{'{ACT_WRITE, 22'h00C7FF}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h00D010}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h00E0F0}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h00FF0F}, 1'b0, NO_RSP},
    '{'{ACT_WRITE, 22'h010333}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h011CCC}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h000123}, 1'b0, NO_RSP},
    '{'{ACT_WRITE, 22'h3FF800}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h005555}, 1'b0, NO_RSP},
    '{'{ACT_READ, 22'h002AAA}, 1'b0, NO_RSP}
  };

  logic clk;
  logic rst;
  logic req_valid;
  logic req_ready;
  tlbpt_pkg::req_t req;
  logic rsp_valid;
  logic rsp_ready;
  tlbpt_pkg::rsp_t rsp;

  logic [PAGE_BITS-1:0] tlb_page [tlbpt_pkg::TLB_ENTRIES];
  logic [FRAME_BITS-1:0] tlb_frame [tlbpt_pkg::TLB_ENTRIES];
  int tlb_used;
  int tlb_oldest;
  logic [FRAME_BITS-1:0] pt_frame [tlbpt_pkg::NUM_VIRTUAL_PAGES];
  bit pt_present [tlbpt_pkg::NUM_VIRTUAL_PAGES];
  bit pt_dirty [tlbpt_pkg::NUM_VIRTUAL_PAGES];
  bit pt_accessed [tlbpt_pkg::NUM_VIRTUAL_PAGES];
  bit frame_used [tlbpt_pkg::NUM_FRAMES];
  logic [PAGE_BITS-1:0] mapped_pages [$];

  tlbpt_pkg::rsp_t expected_translations [$];
  int mismatch_count;
  int hit_count;
  int walk_count;
  int fault_count;
  int exhausted_count;
  int cycle_count;
  bit idle_on;

  tlb_page_table_translator uut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  function automatic tlbpt_pkg::rsp_t translate_access(input tlbpt_pkg::req_t r);
    logic [PAGE_BITS-1:0] page;
    logic [tlbpt_pkg::PAGE_OFFSET_BITS-1:0] offset;
    logic [FRAME_BITS-1:0] frame;
    tlbpt_pkg::rsp_t res;
    bit found;
    page = PAGE_BITS'((r.virt_addr >> tlbpt_pkg::PAGE_OFFSET_BITS) %
                      tlbpt_pkg::NUM_VIRTUAL_PAGES);
    offset = r.virt_addr[tlbpt_pkg::PAGE_OFFSET_BITS-1:0];
    frame = '0;
    found = 1'b0;
    res = '0;
    for (int i = 0; i < tlb_used; i++) begin
      if (!res.tlb_hit && tlb_page[i] == page) begin
        res.tlb_hit = 1'b1;
        frame = tlb_frame[i];
      end
    end
    if (res.tlb_hit) begin
      hit_count++;
    end else begin
      if (pt_present[page]) begin
        frame = pt_frame[page];
        walk_count++;
      end else begin
        res.page_fault = 1'b1;
        fault_count++;
        for (int f = 0; f < tlbpt_pkg::NUM_FRAMES; f++) begin
          if (!found && !frame_used[f]) begin
            found = 1'b1;
            frame = FRAME_BITS'(f);
          end
        end
        if (!found) begin
          frame = '0;
          res.frames_exhausted = 1'b1;
          exhausted_count++;
        end
        frame_used[frame] = 1'b1;
        pt_frame[page] = frame;
        pt_present[page] = 1'b1;
        pt_accessed[page] = 1'b1;
        mapped_pages.push_back(page);
      end
      if (tlb_used < tlbpt_pkg::TLB_ENTRIES) begin
        tlb_page[tlb_used] = page;
        tlb_frame[tlb_used] = frame;
        tlb_used++;
      end else begin
        tlb_page[tlb_oldest] = page;
        tlb_frame[tlb_oldest] = frame;
        tlb_oldest = (tlb_oldest + 1) % tlbpt_pkg::TLB_ENTRIES;
      end
    end
    if (r.action == ACT_WRITE) begin
      pt_dirty[page] = 1'b1;
    end
    res.phys_addr = tlbpt_pkg::PA_WIDTH'((32'(frame) << tlbpt_pkg::PAGE_OFFSET_BITS) |
                                         32'(offset));
    return res;
  endfunction

  task automatic issue_access(input tlbpt_pkg::req_t r, input logic known,
                              input tlbpt_pkg::rsp_t want);
    tlbpt_pkg::rsp_t predicted;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    req_valid = 1'b1;
    req = r;
    do @(posedge clk); while (!req_ready);
    predicted = translate_access(r);
    expected_translations.push_back(known ? want : predicted);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    req_valid = 1'b0;
    while (expected_translations.size() != 0) @(negedge clk);
  endtask

  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_ready = 1'b0;
        repeat ($urandom_range(1, 6) - 1) @(negedge clk);
      end else begin
        rsp_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    tlbpt_pkg::rsp_t want;
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_translations.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT) begin
          $display("ERROR: unexpected result pa=%h hit=%b fault=%b exhausted=%b",
                   rsp.phys_addr, rsp.tlb_hit, rsp.page_fault, rsp.frames_exhausted);
        end
      end else begin
        want = expected_translations.pop_front();
        if (rsp.phys_addr !== want.phys_addr || rsp.tlb_hit !== want.tlb_hit ||
            rsp.page_fault !== want.page_fault ||
            rsp.frames_exhausted !== want.frames_exhausted) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("ERROR: expected pa=%h hit=%b fault=%b exhausted=%b, got pa=%h hit=%b fault=%b exhausted=%b",
                     want.phys_addr, want.tlb_hit, want.page_fault, want.frames_exhausted,
                     rsp.phys_addr, rsp.tlb_hit, rsp.page_fault, rsp.frames_exhausted);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_translations.size());
      $display("tlb_page_table_translator_tb failed");
      $finish;
    end
  end

  initial begin
    tlbpt_pkg::req_t r;
    int pick;
    int dirty_pages;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    idle_on = 1'b1;
    tlb_used = 0;
    tlb_oldest = 0;
    mismatch_count = 0;
    dirty_pages = 0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    for (int row = 0; row < DIR_ROWS; row++) begin
      issue_access(DIR_TABLE[row].access, DIR_TABLE[row].known, DIR_TABLE[row].want);
    end
    wait_for_drain();

    for (int n = 0; n < RANDOM_ACCESSES; n++) begin
      idle_on = !(n >= 600 && n < 750) && (n < RANDOM_ACCESSES - QUIET_TAIL);
      if (n == RANDOM_ACCESSES / 2) begin
        wait_for_drain();
      end
      pick = $urandom_range(0, 99);
      r.action = logic'($urandom_range(0, 1));
      r.virt_addr = tlbpt_pkg::VA_WIDTH'($urandom());
      if (pick < 40 && tlb_used > 0) begin
        r.virt_addr[tlbpt_pkg::VA_WIDTH-1:tlbpt_pkg::PAGE_OFFSET_BITS] =
          tlb_page[$urandom_range(0, tlb_used - 1)];
      end else if (pick < 65 && mapped_pages.size() > 0) begin
        r.virt_addr[tlbpt_pkg::VA_WIDTH-1:tlbpt_pkg::PAGE_OFFSET_BITS] =
          mapped_pages[$urandom_range(0, mapped_pages.size() - 1)];
      end
      issue_access(r, 1'b0, NO_RSP);
    end
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    mismatch_count += expected_translations.size();
    for (int p = 0; p < tlbpt_pkg::NUM_VIRTUAL_PAGES; p++) begin
      dirty_pages += pt_dirty[p];
    end
    $display("Translated %0d accesses: %0d TLB hits, %0d table walks, %0d page faults.",
             hit_count + walk_count + fault_count, hit_count, walk_count, fault_count);
    $display("%0d faults found every frame in use; %0d pages mapped, %0d left dirty.",
             exhausted_count, mapped_pages.size(), dirty_pages);
    if (mismatch_count == 0) begin
      $display("tlb_page_table_translator_tb passed");
    end else begin
      $display("tlb_page_table_translator_tb failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tlbpt_pkg.sv
hdl/tlbpt_tlb.sv
hdl/tlb_page_table_translator.sv
test/tlb_page_table_translator_tb.sv
